// ===== rtl/symbol_table_string_keyed_top_assert.svh =====
// assertion macros used by the symbol table rtl
`ifndef SYMBOL_TABLE_STRING_KEYED_TOP_ASSERT_SVH
`define SYMBOL_TABLE_STRING_KEYED_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define STK_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define STK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define STK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stk_pkg.sv =====
// types, constants and helpers of the string keyed symbol table
package stk_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int MAX_NAME_LEN = 32;

    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W     = $clog2(MAX_NAME_LEN + 1);
    localparam int KEY_IDX_W = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int RNG_W     = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [1:0] {
        FN_LOOKUP   = 2'd0,
        FN_APPEND   = 2'd1,
        FN_SET_TYPE = 2'd2,
        FN_NONE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_DUPLICATE = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_char;
        logic       key_last;
        logic [6:0] range_first;
        logic [6:0] range_end;
        logic [7:0] data_type;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_index;
        logic [7:0] entry_type;
    } result_t;

    typedef logic [MAX_NAME_LEN-1:0][7:0] key_vec_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        key_vec_t         chars;
    } name_row_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
    } name_ctl_t;

    // entry index as carried on the result port
    function automatic logic [5:0] to_index6(input logic [IDX_W-1:0] idx);
        logic [IDX_W+5:0] wide;
        wide = {6'b0, idx};
        return wide[5:0];
    endfunction

endpackage

// ===== rtl/symbol_table_string_keyed_top.sv =====
// top level of the string keyed symbol table
// Symbol table keyed by identifier strings, one character per input transfer.
// Lookup and append characters gather in a key buffer; the character flagged
// key_last triggers the action chosen by its own func. Each stored name owns
// a fixed row of the name memory, so a search reads one whole row per cycle
// and compares it against the key in the shared compare unit, newest entry
// first. A final character runs the search, one row read per stored entry
// compared, through the single name memory port, then the last compare and
// the result step; a set-type item writes each entry of its range, since the
// type memory is written one address a cycle. An overlong name answers
// without a search. item_stall stays high while an item is at work. The
// result sits in an output register, so the next item is taken while an
// earlier result still waits for its transfer. Type codes read as zero until
// first written (a valid bit per entry, cleared by reset); no clearing pass
// is needed after reset.
`include "symbol_table_string_keyed_top_assert.svh"

module symbol_table_string_keyed_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  stk_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_stall,
    output stk_pkg::result_t   result
);

    localparam int IDX_W = stk_pkg::IDX_W;
    localparam int CNT_W = stk_pkg::CNT_W;
    localparam int LEN_W = stk_pkg::LEN_W;
    localparam int RNG_W = stk_pkg::RNG_W;

    // sequencer state
    stk_pkg::state_t    state_reg, state_next;

    // name under assembly
    stk_pkg::key_vec_t  key_buf_reg, key_buf_next;
    logic [LEN_W-1:0]   key_len_reg, key_len_next;
    logic               key_ovf_reg, key_ovf_next;
    logic               is_append_reg, is_append_next;

    // table fill
    logic [CNT_W-1:0]   count_reg, count_next;

    // search pipeline: row read issue, then compare
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]   issue_last;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               name_match;
    stk_pkg::name_ctl_t name_ctl;

    // set-type sweep
    logic [RNG_W-1:0]   sweep_ptr_reg, sweep_ptr_next;
    logic [RNG_W-1:0]   sweep_end_reg, sweep_end_next;
    logic [7:0]         sweep_type_reg, sweep_type_next;
    logic [RNG_W-1:0]   first_ext;
    logic [RNG_W-1:0]   end_ext;
    logic [RNG_W-1:0]   end_clamp;

    // type memory with per-entry valid bits
    logic [7:0]             type_mem [stk_pkg::MAX_ENTRIES];
    logic [stk_pkg::MAX_ENTRIES-1:0] type_vld_reg;
    logic [7:0]             type_rd_reg;
    logic                   type_rd_vld_reg;
    logic                   type_wr_en;
    logic [IDX_W-1:0]       type_wr_addr;
    logic                   type_rd_en;
    logic [IDX_W-1:0]       type_rd_addr;

    // pending result and output register
    stk_pkg::result_t   fin_res_reg, fin_res_next;
    logic               fin_use_type_reg, fin_use_type_next;
    logic               result_valid_reg, result_valid_next;
    stk_pkg::result_t   result_reg, result_next;

    logic               accept;

    stk_name_cmp u_name_cmp (
        .clk     (clk),
        .ctl     (name_ctl),
        .key     (key_buf_reg),
        .key_len (key_len_reg),
        .match   (name_match)
    );

    // clamp the set-type range to the table size
    always_comb
    begin
        first_ext = RNG_W'(item.range_first);
        end_ext   = RNG_W'(item.range_end);
        end_clamp = (end_ext > RNG_W'(stk_pkg::MAX_ENTRIES)) ?
                    RNG_W'(stk_pkg::MAX_ENTRIES) : end_ext;
        issue_last = issue_cnt_reg - 1'b1;
    end

    always_comb
    begin
        state_next        = state_reg;
        key_buf_next      = key_buf_reg;
        key_len_next      = key_len_reg;
        key_ovf_next      = key_ovf_reg;
        is_append_next    = is_append_reg;
        count_next        = count_reg;
        issue_cnt_next    = issue_cnt_reg;
        cmp_valid_next    = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        sweep_ptr_next    = sweep_ptr_reg;
        sweep_end_next    = sweep_end_reg;
        sweep_type_next   = sweep_type_reg;
        fin_res_next      = fin_res_reg;
        fin_use_type_next = fin_use_type_reg;
        name_ctl          = '0;
        type_wr_en        = 1'b0;
        type_wr_addr      = '0;
        type_rd_en        = 1'b0;
        type_rd_addr      = '0;
        // a waiting result leaves on any cycle without stall
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        item_stall = (state_reg != stk_pkg::S_IDLE);
        accept     = item_valid && !item_stall;

        unique case (state_reg)
            stk_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (stk_pkg::func_t'(item.func))
                        stk_pkg::FN_SET_TYPE:
                        begin
                            // empty or inverted range writes nothing
                            if (first_ext < end_clamp)
                            begin
                                sweep_ptr_next  = first_ext;
                                sweep_end_next  = end_clamp;
                                sweep_type_next = item.data_type;
                                state_next      = stk_pkg::S_SWEEP;
                            end
                        end
                        stk_pkg::FN_LOOKUP, stk_pkg::FN_APPEND:
                        begin
                            if (key_len_reg < LEN_W'(stk_pkg::MAX_NAME_LEN))
                            begin
                                key_buf_next[key_len_reg[stk_pkg::KEY_IDX_W-1:0]] =
                                    item.key_char;
                                key_len_next = key_len_reg + 1'b1;
                            end
                            else
                            begin
                                key_ovf_next = 1'b1;
                            end
                            if (item.key_last)
                            begin
                                if (key_ovf_next)
                                begin
                                    // overlong name: no search, nothing stored
                                    fin_res_next.status      = stk_pkg::STAT_FULL;
                                    fin_res_next.entry_index = '0;
                                    fin_res_next.entry_type  = '0;
                                    fin_use_type_next        = 1'b0;
                                    key_len_next             = '0;
                                    key_ovf_next             = 1'b0;
                                    state_next               = stk_pkg::S_FINISH;
                                end
                                else
                                begin
                                    is_append_next = (stk_pkg::func_t'(item.func) ==
                                                      stk_pkg::FN_APPEND);
                                    issue_cnt_next = count_reg;
                                    state_next     = stk_pkg::S_SEARCH;
                                end
                            end
                        end
                        stk_pkg::FN_NONE:
                        begin
                            // unused code, dropped
                        end
                    endcase
                end
            end

            stk_pkg::S_SWEEP:
            begin
                type_wr_en     = 1'b1;
                type_wr_addr   = sweep_ptr_reg[IDX_W-1:0];
                sweep_ptr_next = sweep_ptr_reg + 1'b1;
                if (sweep_ptr_next == sweep_end_reg)
                begin
                    state_next = stk_pkg::S_IDLE;
                end
            end

            stk_pkg::S_SEARCH:
            begin
                // issue the next older row while the previous one is compared
                if (issue_cnt_reg != '0)
                begin
                    name_ctl.rd_en = 1'b1;
                    name_ctl.addr  = issue_last[IDX_W-1:0];
                    issue_cnt_next = issue_last;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_last[IDX_W-1:0];
                end

                if (cmp_valid_reg && name_match)
                begin
                    name_ctl.rd_en = 1'b0;
                    cmp_valid_next = 1'b0;
                    if (is_append_reg)
                    begin
                        fin_res_next.status      = stk_pkg::STAT_DUPLICATE;
                        fin_res_next.entry_index = '0;
                        fin_use_type_next        = 1'b0;
                    end
                    else
                    begin
                        fin_res_next.status      = stk_pkg::STAT_OK;
                        fin_res_next.entry_index = stk_pkg::to_index6(cmp_idx_reg);
                        fin_use_type_next        = 1'b1;
                        type_rd_en               = 1'b1;
                        type_rd_addr             = cmp_idx_reg;
                    end
                    fin_res_next.entry_type = '0;
                    key_len_next            = '0;
                    key_ovf_next            = 1'b0;
                    state_next              = stk_pkg::S_FINISH;
                end
                else if (issue_cnt_reg == '0)
                begin
                    // every stored entry compared without a match
                    fin_res_next.entry_index = '0;
                    fin_res_next.entry_type  = '0;
                    fin_use_type_next        = 1'b0;
                    if (!is_append_reg)
                    begin
                        fin_res_next.status = stk_pkg::STAT_NOT_FOUND;
                    end
                    else if (count_reg == CNT_W'(stk_pkg::MAX_ENTRIES))
                    begin
                        fin_res_next.status = stk_pkg::STAT_FULL;
                    end
                    else
                    begin
                        name_ctl.wr_en           = 1'b1;
                        name_ctl.addr            = count_reg[IDX_W-1:0];
                        count_next               = count_reg + 1'b1;
                        fin_res_next.status      = stk_pkg::STAT_OK;
                        fin_res_next.entry_index =
                            stk_pkg::to_index6(count_reg[IDX_W-1:0]);
                    end
                    key_len_next = '0;
                    key_ovf_next = 1'b0;
                    state_next   = stk_pkg::S_FINISH;
                end
            end

            stk_pkg::S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_next       = fin_res_reg;
                    if (fin_use_type_reg)
                    begin
                        result_next.entry_type = type_rd_vld_reg ? type_rd_reg : 8'd0;
                    end
                    state_next = stk_pkg::S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stk_pkg::S_IDLE;
            key_len_reg      <= '0;
            key_ovf_reg      <= 1'b0;
            count_reg        <= '0;
            issue_cnt_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            type_vld_reg     <= '0;
            type_rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            key_len_reg      <= key_len_next;
            key_ovf_reg      <= key_ovf_next;
            count_reg        <= count_next;
            issue_cnt_reg    <= issue_cnt_next;
            cmp_valid_reg    <= cmp_valid_next;
            result_valid_reg <= result_valid_next;
            if (type_wr_en)
            begin
                type_vld_reg[type_wr_addr] <= 1'b1;
            end
            if (type_rd_en)
            begin
                type_rd_vld_reg <= type_vld_reg[type_rd_addr];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_buf_reg      <= key_buf_next;
        is_append_reg    <= is_append_next;
        cmp_idx_reg      <= cmp_idx_next;
        sweep_ptr_reg    <= sweep_ptr_next;
        sweep_end_reg    <= sweep_end_next;
        sweep_type_reg   <= sweep_type_next;
        fin_res_reg      <= fin_res_next;
        fin_use_type_reg <= fin_use_type_next;
        result_reg       <= result_next;
    end

    // type memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (type_wr_en)
        begin
            type_mem[type_wr_addr] <= sweep_type_reg;
        end
        if (type_rd_en)
        begin
            type_rd_reg <= type_mem[type_rd_addr];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `STK_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(stk_pkg::MAX_ENTRIES), "entry count past table size")
    `STK_ASSERT_HOLDS(a_key_len_bound, key_len_reg <= LEN_W'(stk_pkg::MAX_NAME_LEN), "key length past buffer")
    `STK_ASSERT_IMPLIES(a_read_stored_only, name_ctl.rd_en, (state_reg == stk_pkg::S_SEARCH) && (CNT_W'(name_ctl.addr) < count_reg), "row read outside stored entries")
    `STK_ASSERT_NEXT(a_append_grows, name_ctl.wr_en, count_reg == $past(count_reg) + 1'b1, "append did not grow the table")
    `STK_ASSERT_NEXT(a_finish_delivers, (state_reg == stk_pkg::S_FINISH) && !(result_valid_reg && result_stall), result_valid_reg && (state_reg == stk_pkg::S_IDLE), "finished result not loaded")

endmodule

// ===== rtl/stk_name_cmp.sv =====
// name row memory with the shared whole-name compare unit
module stk_name_cmp (
    input  logic                          clk,
    input  stk_pkg::name_ctl_t            ctl,
    input  stk_pkg::key_vec_t             key,
    input  logic [stk_pkg::LEN_W-1:0]     key_len,
    output logic                          match
);

    stk_pkg::name_row_t mem [stk_pkg::MAX_ENTRIES];
    stk_pkg::name_row_t rd_row_reg;
    stk_pkg::name_row_t wr_row;
    logic               chars_ok;

    always_comb
    begin
        wr_row.len   = key_len;
        wr_row.chars = key;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.addr] <= wr_row;
        end
        if (ctl.rd_en)
        begin
            rd_row_reg <= mem[ctl.addr];
        end
    end

    // characters past the key length do not take part
    always_comb
    begin
        chars_ok = 1'b1;
        for (int j = 0; j < stk_pkg::MAX_NAME_LEN; j++)
        begin
            if ((stk_pkg::LEN_W'(j) < key_len) && (rd_row_reg.chars[j] != key[j]))
            begin
                chars_ok = 1'b0;
            end
        end
        match = chars_ok && (rd_row_reg.len == key_len);
    end

endmodule

// ===== verif/testbench.sv =====
// testbench for the string keyed symbol table: directed and random name traffic
`timescale 1ns / 1ps

module testbench;

    // longest word the stimulus builds, eight characters past the name limit
    localparam int WORD_MAX   = stk_pkg::MAX_NAME_LEN + 8;
    localparam int ITEM_GOAL  = 1300;
    // a final character searches the whole table, a set-type sweeps every slot
    localparam int SETTLE_CYC = 150;

    typedef struct packed {
        logic [7:0]               len;
        logic [WORD_MAX-1:0][7:0] chars;
    } word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    stk_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    stk_pkg::result_t result;

    // idle rates in percent for each side, changed between phases
    int tx_idle_pct = 22;
    int rx_idle_pct = 76;

    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    // our own view of the table, updated at each accepted transfer
    logic [7:0] stored_chars [stk_pkg::MAX_ENTRIES][stk_pkg::MAX_NAME_LEN];
    int         stored_len [stk_pkg::MAX_ENTRIES];
    logic [7:0] stored_type [stk_pkg::MAX_ENTRIES];
    int         stored_count = 0;
    logic [7:0] key_chars [stk_pkg::MAX_NAME_LEN];
    int         key_len = 0;
    bit         key_too_long = 1'b0;

    // results still owed by the block, oldest first
    stk_pkg::result_t awaited_results[$];
    // every name appended so far, hits for later lookups and duplicates
    word_t   name_pool[$];

    symbol_table_string_keyed_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // newest to oldest search for the gathered key
    function automatic bit find_key(output int at);
        int i;
        int j;
        bit same;
        at = 0;
        for (i = stored_count - 1; i >= 0; i--)
        begin
            same = (stored_len[i] == key_len);
            for (j = 0; j < key_len && same; j++)
                same = (stored_chars[i][j] == key_chars[j]);
            if (same)
            begin
                at = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // advance the table view by one accepted transfer, queue any result it owes
    function automatic void apply_to_symbols(input stk_pkg::item_t it);
        stk_pkg::result_t r;
        int               stop;
        int               i;
        int               at;
        r = '0;
        case (stk_pkg::func_t'(it.func))
            stk_pkg::FN_SET_TYPE:
            begin
                // half-open range, clipped at the table size
                stop = (int'(it.range_end) > stk_pkg::MAX_ENTRIES) ?
                       stk_pkg::MAX_ENTRIES : int'(it.range_end);
                for (i = int'(it.range_first); i < stop; i++)
                    stored_type[i] = it.data_type;
            end
            stk_pkg::FN_NONE:
            begin
            end
            default:
            begin
                if (key_len < stk_pkg::MAX_NAME_LEN)
                begin
                    key_chars[key_len] = it.key_char;
                    key_len++;
                end
                else
                    key_too_long = 1'b1;
                if (it.key_last)
                begin
                    if (key_too_long)
                        r.status = stk_pkg::STAT_FULL;
                    else if (stk_pkg::func_t'(it.func) == stk_pkg::FN_LOOKUP)
                    begin
                        if (find_key(at))
                        begin
                            r.status      = stk_pkg::STAT_OK;
                            r.entry_index = 6'(at);
                            r.entry_type  = stored_type[at];
                        end
                        else
                            r.status = stk_pkg::STAT_NOT_FOUND;
                    end
                    else if (find_key(at))
                        r.status = stk_pkg::STAT_DUPLICATE;
                    else if (stored_count >= stk_pkg::MAX_ENTRIES)
                        r.status = stk_pkg::STAT_FULL;
                    else
                    begin
                        // new slot keeps whatever type it already holds
                        for (i = 0; i < key_len; i++)
                            stored_chars[stored_count][i] = key_chars[i];
                        stored_len[stored_count] = key_len;
                        r.status      = stk_pkg::STAT_OK;
                        r.entry_index = 6'(stored_count);
                        stored_count++;
                    end
                    awaited_results.push_back(r);
                    key_len      = 0;
                    key_too_long = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic stk_pkg::item_t make_item(input stk_pkg::func_t f,
                                                 input logic [7:0] ch, input logic last,
                                                 input logic [6:0] lo, input logic [6:0] hi,
                                                 input logic [7:0] dt);
        stk_pkg::item_t it;
        it.func        = f;
        it.key_char    = ch;
        it.key_last    = last;
        it.range_first = lo;
        it.range_end   = hi;
        it.data_type   = dt;
        return it;
    endfunction

    // one transfer on the input side; valid stays up into the next call
    task automatic send_item(input stk_pkg::item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        apply_to_symbols(it);
        if (stk_pkg::func_t'(it.func) != stk_pkg::FN_NONE)
            items_sent++;
    endtask

    // hold off until every owed result has come out, or give up after a while
    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        item_valid <= 1'b0;
        while (awaited_results.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        if (awaited_results.size() != 0)
        begin
            $display("%t: %0d results never arrived", $realtime, awaited_results.size());
            mismatches += awaited_results.size();
            awaited_results.delete();
        end
    endtask

    // ranges mostly near the table size, now and then any 7-bit value
    task automatic send_type_range();
        logic [6:0] lo;
        logic [6:0] hi;
        if ($urandom_range(4) == 0)
        begin
            lo = 7'($urandom);
            hi = 7'($urandom);
        end
        else
        begin
            lo = 7'($urandom_range(stk_pkg::MAX_ENTRIES));
            hi = 7'($urandom_range(stk_pkg::MAX_ENTRIES + 6));
        end
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'($urandom), 1'($urandom), lo, hi,
                            8'($urandom)));
    endtask

    task automatic send_ignored();
        send_item(make_item(stk_pkg::FN_NONE, 8'($urandom), 1'($urandom), 7'($urandom),
                            7'($urandom), 8'($urandom)));
    endtask

    // name characters, with stray set-type and unused-code transfers mixed in
    // and now and then a non-final character carrying the other key function
    task automatic send_word(input stk_pkg::func_t f, input word_t w);
        stk_pkg::func_t cf;
        int             i;
        for (i = 0; i < int'(w.len); i++)
        begin
            if ($urandom_range(24) == 0)
                send_type_range();
            if ($urandom_range(39) == 0)
                send_ignored();
            cf = f;
            if (i < int'(w.len) - 1 && $urandom_range(9) == 0)
                cf = (f == stk_pkg::FN_LOOKUP) ? stk_pkg::FN_APPEND : stk_pkg::FN_LOOKUP;
            send_item(make_item(cf, w.chars[i], i == int'(w.len) - 1, 7'($urandom),
                                7'($urandom), 8'($urandom)));
        end
    endtask

    // small alphabet most of the time so prefixes and duplicates are common
    function automatic word_t random_word(input int len);
        word_t w;
        int    i;
        w     = '0;
        w.len = 8'(len);
        for (i = 0; i < len; i++)
            w.chars[i] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(3));
        return w;
    endfunction

    function automatic int random_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(4, 1);
        if (r < 90)
            return $urandom_range(12, 5);
        if (r < 96)
            return $urandom_range(stk_pkg::MAX_NAME_LEN, 13);
        return $urandom_range(WORD_MAX, stk_pkg::MAX_NAME_LEN + 1);
    endfunction

    function automatic word_t pool_pick();
        return name_pool[$urandom_range(name_pool.size() - 1)];
    endfunction

    // extremes of every field, each function, ranges that write nothing,
    // the unused code, and a name interrupted by other transfers
    task automatic test_directed();
        // empty table miss
        send_item(make_item(stk_pkg::FN_LOOKUP, "a", 1'b1, 7'd0, 7'd0, 8'd0));
        send_item(make_item(stk_pkg::FN_APPEND, 8'h00, 1'b1, 7'd0, 7'd0, 8'd0));
        send_item(make_item(stk_pkg::FN_APPEND, 8'hff, 1'b1, 7'h7f, 7'h7f, 8'hff));
        // duplicate
        send_item(make_item(stk_pkg::FN_APPEND, 8'h00, 1'b1, 7'd0, 7'd0, 8'd0));
        // every slot
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'h00, 1'b0, 7'd0, 7'h7f, 8'hff));
        send_item(make_item(stk_pkg::FN_LOOKUP, 8'hff, 1'b1, 7'd0, 7'd0, 8'd0));
        // inverted
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'hff, 1'b1, 7'h7f, 7'd0, 8'd0));
        // empty
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'h00, 1'b0, 7'd1, 7'd1, 8'd0));
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'h00, 1'b0, 7'd0, 7'd1, 8'd0));
        send_item(make_item(stk_pkg::FN_LOOKUP, 8'h00, 1'b1, 7'd0, 7'd0, 8'd0));
        // ignored
        send_item(make_item(stk_pkg::FN_NONE, 8'h00, 1'b1, 7'd0, 7'd0, 8'd0));
        // lookup character, then set-type and unused code mid-name, append decides
        send_item(make_item(stk_pkg::FN_LOOKUP, "x", 1'b0, 7'd0, 7'd0, 8'd0));
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'h00, 1'b0, 7'd2, 7'd64, 8'h5a));
        send_item(make_item(stk_pkg::FN_NONE, 8'hff, 1'b1, 7'h7f, 7'h7f, 8'hff));
        // keeps 0x5a
        send_item(make_item(stk_pkg::FN_APPEND, "y", 1'b1, 7'd0, 7'd0, 8'd0));
        send_item(make_item(stk_pkg::FN_APPEND, "x", 1'b0, 7'd0, 7'd0, 8'd0));
        send_item(make_item(stk_pkg::FN_LOOKUP, "y", 1'b1, 7'd0, 7'd0, 8'd0));
        // prefix miss
        send_item(make_item(stk_pkg::FN_LOOKUP, "x", 1'b1, 7'd0, 7'd0, 8'd0));
        // past the end
        send_item(make_item(stk_pkg::FN_SET_TYPE, 8'h00, 1'b0, 7'd64, 7'h7f, 8'h11));
    endtask

    // names at the length limit and one past it
    task automatic test_long_names();
        word_t w;
        w = random_word(stk_pkg::MAX_NAME_LEN);
        send_word(stk_pkg::FN_APPEND, w);
        name_pool.push_back(w);
        send_word(stk_pkg::FN_LOOKUP, w);
        w.len = 8'(stk_pkg::MAX_NAME_LEN + 1);
        w.chars[stk_pkg::MAX_NAME_LEN] = 8'($urandom);
        send_word(stk_pkg::FN_LOOKUP, w);           // stored prefix, still too long
        send_word(stk_pkg::FN_APPEND, w);
        w.len = 8'(stk_pkg::MAX_NAME_LEN - 1);
        send_word(stk_pkg::FN_LOOKUP, w);
        send_word(stk_pkg::FN_APPEND, random_word(WORD_MAX));
    endtask

    // mostly well formed appends and lookups with random content, some noise
    task automatic test_random_mix(input int upto);
        word_t w;
        int    r;
        while (items_sent < upto)
        begin
            r = $urandom_range(99);
            if (r < 30)
            begin
                if (r < 8 && name_pool.size() != 0)
                    send_word(stk_pkg::FN_APPEND, pool_pick());
                else
                begin
                    w = random_word(random_len());
                    send_word(stk_pkg::FN_APPEND, w);
                    name_pool.push_back(w);
                end
            end
            else if (r < 70)
            begin
                if (name_pool.size() == 0 || r < 40)
                    send_word(stk_pkg::FN_LOOKUP, random_word(random_len()));
                else
                    send_word(stk_pkg::FN_LOOKUP, pool_pick());
            end
            else if (r < 78 && name_pool.size() != 0)
            begin
                w     = pool_pick();
                w.len = 8'($urandom_range(int'(w.len), 1));
                send_word(stk_pkg::FN_LOOKUP, w);
            end
            else if (r < 92)
                send_type_range();
            else if (r < 95)
                send_ignored();
            else
                send_word(stk_pkg::func_t'($urandom_range(1)),
                          random_word($urandom_range(WORD_MAX, 33)));
        end
    endtask

    // fill every slot, then refuse new names while duplicates still report as such
    task automatic test_table_full();
        word_t w;
        int    k;
        while (stored_count < stk_pkg::MAX_ENTRIES)
        begin
            w = random_word($urandom_range(3, 1));
            send_word(stk_pkg::FN_APPEND, w);
            name_pool.push_back(w);
        end
        for (k = 0; k < 6; k++)
        begin
            send_word(stk_pkg::FN_APPEND, random_word($urandom_range(6, 1)));
            send_word(stk_pkg::FN_APPEND, pool_pick());
            send_word(stk_pkg::FN_LOOKUP, name_pool[0]);
            send_word(stk_pkg::FN_LOOKUP, pool_pick());
        end
    endtask

    // output side: random stall, and each result transfer checked against the
    // oldest owed result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%t: result with none expected, actual %h", $realtime, result);
                    mismatches++;
                end
                else
                begin
                    if (result.status !== awaited_results[0].status)
                    begin
                        $display("%t: status expected %0d actual %0d", $realtime,
                                 awaited_results[0].status, result.status);
                        mismatches++;
                    end
                    if (result.entry_index !== awaited_results[0].entry_index)
                    begin
                        $display("%t: entry_index expected %0d actual %0d", $realtime,
                                 awaited_results[0].entry_index, result.entry_index);
                        mismatches++;
                    end
                    if (result.entry_type !== awaited_results[0].entry_type)
                    begin
                        $display("%t: entry_type expected %0d actual %0d", $realtime,
                                 awaited_results[0].entry_type, result.entry_type);
                        mismatches++;
                    end
                    status_seen[awaited_results[0].status]++;
                    void'(awaited_results.pop_front());
                    results_checked++;
                end
            end
            result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin
        foreach (stored_type[i])
        begin
            stored_type[i] = 8'd0;
            stored_len[i]  = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender mostly busy, receiver mostly stalling
        test_directed();
        test_random_mix(450);
        // sender holds back until the block has nothing left in flight
        wait_drained(200000);

        // phase two: sender mostly idle, receiver mostly ready
        tx_idle_pct = 76;
        rx_idle_pct = 22;
        test_long_names();
        test_random_mix(800);

        // phase three: back to back on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_table_full();
        test_random_mix(ITEM_GOAL);

        item_valid <= 1'b0;
        wait_drained(200000);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("covered %0d transfers in and %0d results, table ended with %0d of %0d entries",
                 items_sent, results_checked, stored_count, stk_pkg::MAX_ENTRIES);
        $display("results by status: ok %0d, not found %0d, duplicate %0d, full or too long %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #30ms;
        $display("testbench failed");
        $finish;
    end

endmodule
